### design/pcctc_pkg.sv
`default_nettype none
package pcctc_pkg;

	localparam int ADDR_W = 27;
	localparam int TEXEL_W = 12;

	localparam logic [7:0] REG_FLIP = 8'd0;
	localparam logic [7:0] REG_SCALE = 8'd1;
	localparam logic [7:0] REG_CROP_X = 8'd2;
	localparam logic [7:0] REG_CROP_Y = 8'd3;
	localparam logic [7:0] REG_CROP_Z = 8'd4;
	localparam logic [7:0] REG_OFFSET = 8'd5;
	localparam logic [7:0] REG_GEOM = 8'd6;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_POINT = 1'b1;

	typedef struct packed {
		logic [2:0] flip;
		logic signed [23:0] scale;
		logic [63:0] crop_x;
		logic [63:0] crop_y;
		logic [63:0] crop_z;
		logic [47:0] offset;
		logic [40:0] geom;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [21:0] tex_addr;
		logic [7:0] tex_byte;
		logic last;
		logic keep;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [TEXEL_W-1:0] col;
		logic [TEXEL_W-1:0] row;
	} entry_t;

endpackage
`default_nettype wire

### design/pcctc_front.sv
`default_nettype none
module pcctc_front import pcctc_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire cfg_t cfg,
	input wire in_valid,
	output logic in_stall,
	input wire func,
	input wire [21:0] tex_addr,
	input wire [7:0] tex_byte,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] pos_y,
	input wire signed [31:0] pos_z,
	input wire signed [19:0] tex_u,
	input wire signed [19:0] tex_v,
	input wire last_point,
	input wire q_full,
	output logic push,
	output entry_t push_entry
);

	logic valid_s1;
	logic func_s1, last_s1;
	logic [21:0] addr_s1;
	logic [7:0] byte_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic signed [19:0] u_s1, v_s1;
	logic signed [32:0] xf, yf, zf;
	logic keep;

	function automatic logic signed [32:0] flip_ax(logic signed [31:0] v, logic keep_sign);
		logic signed [32:0] e;
		e = {v[31], v};
		return keep_sign ? e : -e;
	endfunction

	function automatic logic in_rng(logic signed [32:0] v, logic [63:0] r);
		logic signed [32:0] lo, hi;
		lo = {r[31], r[31:0]};
		hi = {r[63], r[63:32]};
		return (v >= lo) && (v <= hi);
	endfunction

	// round to nearest texel and clamp to the texture size
	function automatic logic [TEXEL_W-1:0] texel(logic signed [19:0] c, logic [TEXEL_W-1:0] size);
		logic signed [33:0] t;
		logic [17:0] k;
		t = 34'(c * $signed({1'b0, size})) + 34'sd32768;
		k = t[33:16];
		if (size == '0 || t[33])
			return '0;
		else if (k > {6'd0, size - 1'b1})
			return size - 1'b1;
		else
			return k[TEXEL_W-1:0];
	endfunction

	assign in_stall = valid_s1 && q_full;
	assign push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			func_s1 <= func;
			last_s1 <= last_point;
			addr_s1 <= tex_addr;
			byte_s1 <= tex_byte;
			x_s1 <= pos_x;
			y_s1 <= pos_y;
			z_s1 <= pos_z;
			u_s1 <= tex_u;
			v_s1 <= tex_v;
		end
	end

	always_comb begin
		xf = flip_ax(x_s1, cfg.flip[0]);
		yf = flip_ax(y_s1, cfg.flip[1]);
		zf = flip_ax(z_s1, cfg.flip[2]);
		keep = (zf != '0) && in_rng(zf, cfg.crop_z) && in_rng(xf, cfg.crop_x)
			&& in_rng(yf, cfg.crop_y);
		push_entry.func = func_s1;
		push_entry.tex_addr = addr_s1;
		push_entry.tex_byte = byte_s1;
		push_entry.last = last_s1;
		push_entry.keep = keep;
		push_entry.x = xf[31:0];
		push_entry.y = yf[31:0];
		push_entry.z = zf[31:0];
		push_entry.col = texel(u_s1, cfg.geom[11:0]);
		push_entry.row = texel(v_s1, cfg.geom[23:12]);
	end

endmodule
`default_nettype wire

### design/pcctc_queue.sv
`default_nettype none
module pcctc_queue import pcctc_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire push,
	input wire entry_t push_entry,
	output logic full,
	input wire pop,
	output logic empty,
	output entry_t head
);

	entry_t slot_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full = cnt_q[2];
	assign empty = cnt_q == 3'd0;
	assign head = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			if (push && !pop)
				cnt_q <= cnt_q + 3'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 3'd1)
		else $error("queue count off");

endmodule
`default_nettype wire

### design/pcctc_back.sv
`default_nettype none
module pcctc_back import pcctc_pkg::*; #(
	parameter int TEX_BYTES = 4194304
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_t cfg,
	input wire q_empty,
	input wire entry_t head,
	output logic pop,
	output logic out_valid,
	input wire out_stall,
	output logic kept,
	output logic frame_last,
	output logic signed [15:0] out_x_mm,
	output logic signed [15:0] out_y_mm,
	output logic signed [15:0] out_z_mm,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red
);

	localparam int AW = $clog2(TEX_BYTES);
	localparam int RW = AW - 2;
	localparam int BANK_DEPTH = TEX_BYTES / 4;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	entry_t ent_s1;
	logic func_s2, keep_s2, last_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [7:0] byte_s2;
	logic signed [55:0] prod_s2 [3];
	logic keep_s3, keep_s4, keep_s5, keep_s6;
	logic last_s3, last_s4, last_s5, last_s6;
	logic [1:0] lo_s3;
	logic [2:0] neg_s3;
	logic [40:0] mag_s3 [3];
	logic [7:0] rd_s3 [4];
	logic signed [50:0] q_s4 [3];
	logic [7:0] bgr_s4 [3], bgr_s5 [3], bgr_s6 [3];
	logic signed [51:0] sum_s5 [3];
	logic signed [15:0] mm_s6 [3];
	logic [ADDR_W-1:0] addr_next;
	logic [AW-1:0] a2;
	logic [RW-1:0] base_row;

	assign adv = !valid_s6 || !out_stall;
	assign pop = adv && !q_empty;

	always_comb begin
		if (ent_s1.func == FUNC_WRITE)
			addr_next = ADDR_W'(ent_s1.tex_addr);
		else
			addr_next = ADDR_W'(ent_s1.col * cfg.geom[26:24])
				+ ADDR_W'(ent_s1.row * cfg.geom[40:27]);
		a2 = addr_s2[AW-1:0];
		base_row = a2[AW-1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !q_empty;
			valid_s2 <= valid_s1;
			// write requests end at the memory
			valid_s3 <= valid_s2 && (func_s2 == FUNC_POINT);
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1 <= head;
			func_s2 <= ent_s1.func;
			keep_s2 <= ent_s1.keep;
			last_s2 <= ent_s1.last;
			addr_s2 <= addr_next;
			byte_s2 <= ent_s1.tex_byte;
			prod_s2[0] <= ent_s1.x * cfg.scale;
			prod_s2[1] <= ent_s1.y * cfg.scale;
			prod_s2[2] <= ent_s1.z * cfg.scale;
			keep_s3 <= keep_s2;
			last_s3 <= last_s2;
			lo_s3 <= a2[1:0];
			keep_s4 <= keep_s3;
			last_s4 <= last_s3;
			keep_s5 <= keep_s4;
			last_s5 <= last_s4;
			keep_s6 <= keep_s5;
			last_s6 <= last_s5;
			for (int i = 0; i < 3; i++) begin
				logic [55:0] mag;
				logic [50:0] m;
				logic signed [51:0] t;
				mag = prod_s2[i][55] ? 56'(-prod_s2[i]) : 56'(prod_s2[i]);
				neg_s3[i] <= prod_s2[i][55];
				// anything at or above 2^40 saturates after the x1000 anyway
				mag_s3[i] <= (mag[55:40] != '0) ? {1'b1, 40'd0} : {1'b0, mag[39:0]};
				m = 51'(mag_s3[i]) * 51'd1000;
				if (m > 51'(64'h2_0000_0000_0000))
					m = 51'(64'h2_0000_0000_0000);
				q_s4[i] <= neg_s3[i] ? -$signed(m) : $signed(m);
				bgr_s4[i] <= rd_s3[2'(lo_s3 + 2'(i))];
				sum_s5[i] <= 52'(q_s4[i])
					+ {{4{cfg.offset[16*i+15]}}, cfg.offset[16*i +: 16], 32'd0};
				bgr_s5[i] <= bgr_s4[i];
				// truncate toward zero, then saturate
				t = sum_s5[i] + (sum_s5[i][51] ? 52'sh0_FFFF_FFFF : 52'sd0);
				if ($signed(t[51:32]) > 20'sd32767)
					mm_s6[i] <= 16'sh7FFF;
				else if ($signed(t[51:32]) < -20'sd32768)
					mm_s6[i] <= 16'sh8000;
				else
					mm_s6[i] <= t[47:32];
				bgr_s6[i] <= bgr_s5[i];
			end
		end
	end

	// four byte lanes so three neighboring bytes come from distinct banks
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [7:0] mem [BANK_DEPTH];
		logic [RW-1:0] rrow;
		assign rrow = (2'(k) >= a2[1:0]) ? base_row : base_row + 1'b1;
		always_ff @(posedge clk) begin
			if (adv && valid_s2 && func_s2 == FUNC_WRITE && a2[1:0] == 2'(k))
				mem[base_row] <= byte_s2;
			if (adv)
				rd_s3[k] <= mem[rrow];
		end
	end

	assign out_valid = valid_s6;
	assign kept = keep_s6;
	assign frame_last = last_s6;
	assign out_x_mm = keep_s6 ? mm_s6[0] : '0;
	assign out_y_mm = keep_s6 ? mm_s6[1] : '0;
	assign out_z_mm = keep_s6 ? mm_s6[2] : '0;
	assign blue = keep_s6 ? bgr_s6[0] : '0;
	assign green = keep_s6 ? bgr_s6[1] : '0;
	assign red = keep_s6 ? bgr_s6[2] : '0;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kept |-> out_x_mm == '0 && blue == '0 && red == '0)
		else $error("dropped point carries data");
	a_no_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s2 && func_s2 == FUNC_WRITE |=> !valid_s3)
		else $error("write request produced a result");
	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_s1)
		else $error("popped request lost");

endmodule
`default_nettype wire

### design/point_cloud_crop_transform_colorize.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid / in_stall | func, tex_addr, tex_byte, pos_*, tex_u/v, last_point
// out     | out | out_valid/out_stall | kept, frame_last, out_*_mm, blue, green, red
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low
// the back pipeline has six stages (multiply, x1000, offset, truncate)
// texture memory is four byte-wide banks, one write and one read port each
// out_stall freezes the back pipeline; a 4-entry queue lets the front keep accepting until it fills
// reset clears control and the config registers; texture contents are undefined until written
`default_nettype none
module point_cloud_crop_transform_colorize import pcctc_pkg::*; #(
	parameter int TEX_BYTES = 4194304
) (
	input wire clk,
	input wire arst_n,
	input wire cfg_valid,
	output logic cfg_ready,
	input wire [7:0] cfg_index,
	input wire [63:0] cfg_data,
	input wire in_valid,
	output logic in_stall,
	input wire func,
	input wire [21:0] tex_addr,
	input wire [7:0] tex_byte,
	input wire signed [31:0] pos_x,
	input wire signed [31:0] pos_y,
	input wire signed [31:0] pos_z,
	input wire signed [19:0] tex_u,
	input wire signed [19:0] tex_v,
	input wire last_point,
	output logic out_valid,
	input wire out_stall,
	output logic kept,
	output logic frame_last,
	output logic signed [15:0] out_x_mm,
	output logic signed [15:0] out_y_mm,
	output logic signed [15:0] out_z_mm,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red
);

	cfg_t cfg_q;
	logic push, pop, q_full, q_empty;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flip <= 3'd0;
			cfg_q.scale <= 24'sd65536;
			cfg_q.crop_x <= 64'h7FFF_FFFF_8000_0000;
			cfg_q.crop_y <= 64'h7FFF_FFFF_8000_0000;
			cfg_q.crop_z <= 64'h7FFF_FFFF_8000_0000;
			cfg_q.offset <= '0;
			cfg_q.geom <= 41'd257750336128;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FLIP: cfg_q.flip <= cfg_data[2:0];
				REG_SCALE: cfg_q.scale <= cfg_data[23:0];
				REG_CROP_X: cfg_q.crop_x <= cfg_data;
				REG_CROP_Y: cfg_q.crop_y <= cfg_data;
				REG_CROP_Z: cfg_q.crop_z <= cfg_data;
				REG_OFFSET: cfg_q.offset <= cfg_data[47:0];
				REG_GEOM: cfg_q.geom <= cfg_data[40:0];
				default: ;
			endcase
		end
	end

	pcctc_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .tex_addr(tex_addr), .tex_byte(tex_byte),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v), .last_point(last_point),
		.q_full(q_full), .push(push), .push_entry(push_entry)
	);

	pcctc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_entry(push_entry), .full(q_full),
		.pop(pop), .empty(q_empty), .head(head)
	);

	pcctc_back #(.TEX_BYTES(TEX_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_empty(q_empty), .head(head), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall),
		.kept(kept), .frame_last(frame_last),
		.out_x_mm(out_x_mm), .out_y_mm(out_y_mm), .out_z_mm(out_z_mm),
		.blue(blue), .green(green), .red(red)
	);

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import pcctc_pkg::*;

	localparam int unsigned TEX_SIZE = 4194304;

	typedef struct packed {
		logic func;
		logic [21:0] addr;
		logic [7:0] data;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic [19:0] u;
		logic [19:0] v;
		logic last;
	} point_req_t;

	typedef struct packed {
		logic kept;
		logic last;
		logic [15:0] x_mm;
		logic [15:0] y_mm;
		logic [15:0] z_mm;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} color_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic func = 1'b0;
	logic [21:0] tex_addr = '0;
	logic [7:0] tex_byte = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic signed [19:0] tex_u = '0;
	logic signed [19:0] tex_v = '0;
	logic last_point = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kept;
	logic frame_last;
	logic signed [15:0] out_x_mm;
	logic signed [15:0] out_y_mm;
	logic signed [15:0] out_z_mm;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	point_req_t pending_reqs[$];
	color_point_t expected_points[$];
	logic [63:0] shadow_reg [0:6];
	logic [7:0] tex_mem [int unsigned];
	bit tex_seen [int unsigned];
	int errors = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit long_hold_req = 0;
	bit quiet = 0;

	point_cloud_crop_transform_colorize DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .func(func), .tex_addr(tex_addr),
		.tex_byte(tex_byte), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v), .last_point(last_point),
		.out_valid(out_valid), .out_stall(out_stall), .kept(kept),
		.frame_last(frame_last), .out_x_mm(out_x_mm), .out_y_mm(out_y_mm),
		.out_z_mm(out_z_mm), .blue(blue), .green(green), .red(red)
	);

	always #2 clk = ~clk;

	function automatic bit within_crop(longint v, logic [63:0] rg);
		longint lo;
		longint hi;
		lo = longint'($signed(rg[31:0]));
		hi = longint'($signed(rg[63:32]));
		return v >= lo && v <= hi;
	endfunction

	function automatic longint oriented_axis(logic [31:0] raw, logic keep_sign);
		longint a;
		a = longint'($signed(raw));
		return keep_sign ? a : -a;
	endfunction

	function automatic logic [15:0] axis_to_mm(longint v, longint s, longint off);
		longint p;
		longint q;
		longint r;
		longint unsigned mag;
		bit neg;
		p = v * s;
		neg = p < 0;
		mag = neg ? longint'(-p) : p;
		mag = mag * 1000;
		if (mag > (64'd1 << 49))
			mag = 64'd1 << 49;
		q = neg ? -longint'(mag) : longint'(mag);
		q = q + off * 64'sd4294967296;
		r = (q >= 0) ? (q >>> 32) : -((-q) >>> 32);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic longint unsigned texel_coord(logic [19:0] c, longint unsigned size);
		longint t;
		longint unsigned k;
		if (size == 0)
			return 0;
		t = longint'($signed(c)) * longint'(size) + 32768;
		if (t < 0)
			return 0;
		k = t >> 16;
		if (k > size - 1)
			k = size - 1;
		return k;
	endfunction

	// crop decision and texel byte address under the current register values
	function automatic void locate_texel(point_req_t q, output bit keep,
			output int unsigned base);
		longint x, y, z;
		longint unsigned col, row, a;
		logic [63:0] geom;
		x = oriented_axis(q.px, shadow_reg[REG_FLIP][0]);
		y = oriented_axis(q.py, shadow_reg[REG_FLIP][1]);
		z = oriented_axis(q.pz, shadow_reg[REG_FLIP][2]);
		keep = z != 0 && within_crop(z, shadow_reg[REG_CROP_Z]) &&
			within_crop(x, shadow_reg[REG_CROP_X]) && within_crop(y, shadow_reg[REG_CROP_Y]);
		geom = shadow_reg[REG_GEOM];
		col = texel_coord(q.u, geom[11:0]);
		row = texel_coord(q.v, geom[23:12]);
		a = col * geom[26:24] + row * geom[40:27];
		base = 32'(a % TEX_SIZE);
	endfunction

	function automatic color_point_t colorize(point_req_t q);
		color_point_t res;
		bit keep;
		int unsigned base;
		longint s;
		res = '0;
		res.last = q.last;
		locate_texel(q, keep, base);
		if (keep) begin
			s = longint'($signed(shadow_reg[REG_SCALE][23:0]));
			res.kept = 1'b1;
			res.x_mm = axis_to_mm(oriented_axis(q.px, shadow_reg[REG_FLIP][0]), s,
				longint'($signed(shadow_reg[REG_OFFSET][15:0])));
			res.y_mm = axis_to_mm(oriented_axis(q.py, shadow_reg[REG_FLIP][1]), s,
				longint'($signed(shadow_reg[REG_OFFSET][31:16])));
			res.z_mm = axis_to_mm(oriented_axis(q.pz, shadow_reg[REG_FLIP][2]), s,
				longint'($signed(shadow_reg[REG_OFFSET][47:32])));
			res.b = tex_mem[base];
			res.g = tex_mem[(base + 1) % TEX_SIZE];
			res.r = tex_mem[(base + 2) % TEX_SIZE];
		end
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (func == FUNC_WRITE)
					tex_mem[tex_addr] = tex_byte;
				else
					expected_points.push_back(colorize({func, tex_addr, tex_byte, pos_x,
						pos_y, pos_z, tex_u, tex_v, last_point}));
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					point_req_t q;
					q = pending_reqs.pop_front();
					{func, tex_addr, tex_byte, pos_x, pos_y, pos_z, tex_u, tex_v, last_point}
						<= q;
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 8);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				color_point_t got;
				color_point_t want;
				got = {kept, frame_last, out_x_mm, out_y_mm, out_z_mm, blue, green, red};
				if (expected_points.size() == 0) begin
					$display("%0t: result with nothing expected, got %p", $realtime, got);
					errors++;
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %p actual %p", $realtime, want, got);
						errors++;
					end
				end
			end
			if (long_hold_req) begin
				hold_left = 150;
				long_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FLIP: shadow_reg[REG_FLIP] = val & 64'h7;
			REG_SCALE: shadow_reg[REG_SCALE] = val & 64'hFFFFFF;
			REG_CROP_X, REG_CROP_Y, REG_CROP_Z: shadow_reg[idx] = val;
			REG_OFFSET: shadow_reg[REG_OFFSET] = val & 64'hFFFF_FFFF_FFFF;
			REG_GEOM: shadow_reg[REG_GEOM] = val & 64'h1FF_FFFF_FFFF;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic void add_write(logic [21:0] a, logic [7:0] d);
		pending_reqs.push_back({FUNC_WRITE, a, d, 32'd0, 32'd0, 32'd0, 20'd0, 20'd0, 1'b0});
		tex_seen[a] = 1;
	endfunction

	// a kept point must only read texture bytes that were written before it
	function automatic void add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [19:0] u, logic [19:0] v, logic last);
		point_req_t q;
		bit keep;
		int unsigned base;
		int unsigned a;
		q = {FUNC_POINT, 22'($urandom), 8'($urandom), x, y, z, u, v, last};
		locate_texel(q, keep, base);
		if (keep)
			for (int k = 0; k < 3; k++) begin
				a = (base + k) % TEX_SIZE;
				if (!tex_seen.exists(a))
					add_write(a[21:0], 8'($urandom));
			end
		pending_reqs.push_back(q);
	endfunction

	function automatic logic [31:0] near_value();
		return 32'($signed($urandom_range(0, 655360)) - 327680);
	endfunction

	function automatic void random_reqs(int n);
		logic [31:0] z;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				add_write(22'($urandom), 8'($urandom));
			end else if ($urandom_range(0, 9) < 8) begin
				z = ($urandom_range(0, 19) == 0) ? 32'd0 : near_value();
				add_point(near_value(), near_value(), z,
					20'($urandom_range(0, 70000)) - 20'd2000,
					20'($urandom_range(0, 70000)) - 20'd2000, 1'($urandom));
			end else begin
				add_point($urandom, $urandom, $urandom, 20'($urandom), 20'($urandom),
					1'($urandom));
			end
		end
	endfunction

	function automatic logic [63:0] near_crop();
		logic [31:0] lo;
		logic [31:0] hi;
		lo = 32'(-$signed($urandom_range(0, 300000)));
		hi = 32'($urandom_range(0, 300000));
		return {hi, lo};
	endfunction

	function automatic logic [63:0] random_geom(int unsigned wmax);
		logic [63:0] g;
		g = '0;
		g[11:0] = 12'($urandom_range(0, wmax));
		g[23:12] = 12'($urandom_range(0, wmax));
		g[26:24] = 3'($urandom);
		g[40:27] = 14'($urandom);
		return g;
	endfunction

	task automatic random_config(bit wild_crop);
		write_reg(REG_FLIP, 64'($urandom));
		write_reg(REG_SCALE, 64'($urandom));
		write_reg(REG_CROP_X, wild_crop ? {$urandom, $urandom} : near_crop());
		write_reg(REG_CROP_Y, wild_crop ? {$urandom, $urandom} : near_crop());
		write_reg(REG_CROP_Z, wild_crop ? {$urandom, $urandom} : near_crop());
		write_reg(REG_OFFSET, {$urandom, $urandom});
		write_reg(REG_GEOM, random_geom(4095));
	endtask

	initial begin
		shadow_reg[REG_FLIP] = 64'd0;
		shadow_reg[REG_SCALE] = 64'd65536;
		shadow_reg[REG_CROP_X] = 64'd9223372034707292160;
		shadow_reg[REG_CROP_Y] = 64'd9223372034707292160;
		shadow_reg[REG_CROP_Z] = 64'd9223372034707292160;
		shadow_reg[REG_OFFSET] = 64'd0;
		shadow_reg[REG_GEOM] = 64'd257750336128;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed requests under reset values
		add_write(22'd0, 8'h00);
		add_write(22'h3FFFFF, 8'hFF);
		add_point(32'h8000_0000, 32'd65536, 32'h8000_0000, 20'd0, 20'd0, 1'b0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd65536, 20'd65536, 1'b1);
		add_point(32'd65536, 32'd65536, 32'd0, 20'd32768, 20'd32768, 1'b1);
		add_point(-32'sd65536, 32'd100, -32'sd131072, 20'h80000, 20'h7FFFF, 1'b0);
		add_point(32'd1, 32'hFFFF_FFFF, 32'd1, 20'h7FFFF, 20'h80000, 1'b1);
		add_point(32'd0, 32'd0, -32'sd65536, 20'd65535, 20'd1, 1'b0);
		add_point(32'h4000_0000, -32'sd300000, -32'sd1, 20'd12345, 20'd54321, 1'b1);
		wait_idle();

		// extremes of the scale and offsets, unknown register index
		write_reg(REG_FLIP, 64'd7);
		write_reg(REG_SCALE, 64'd8388607);
		write_reg(REG_CROP_X, near_crop());
		write_reg(REG_CROP_Y, near_crop());
		write_reg(REG_CROP_Z, near_crop());
		write_reg(REG_OFFSET, 64'h0000_5A5A_8000_7FFF);
		write_reg(REG_GEOM, random_geom(64));
		write_reg(8'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		random_reqs(100);
		wait_idle();

		write_reg(REG_FLIP, 64'd0);
		write_reg(REG_SCALE, 64'h80_0000);
		write_reg(REG_CROP_X, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_CROP_Y, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_CROP_Z, 64'h7FFF_FFFF_8000_0000);
		write_reg(REG_OFFSET, 64'h0000_8000_7FFF_8000);
		write_reg(REG_GEOM, 64'h1FF_FFFF_FFFF);
		random_reqs(60);
		// receiver holds off while the queue keeps offering requests
		long_hold_req = 1;
		wait_idle();

		// crop minimum above maximum on x
		write_reg(REG_CROP_X, 64'h8000_0000_7FFF_FFFF);
		random_reqs(50);
		wait_idle();

		// zero texture width and height
		write_reg(REG_CROP_X, near_crop());
		write_reg(REG_GEOM, 64'h1FF_FF00_0000);
		random_reqs(60);
		wait_idle();

		random_config(1'b0);
		random_reqs(80);
		wait_idle();
		random_reqs(80);
		wait_idle();

		random_config(1'b1);
		random_reqs(80);
		wait_idle();

		random_config(1'b0);
		random_reqs(100);
		wait_idle();

		quiet = 1;
		random_config(1'b0);
		random_reqs(100);
		wait_idle();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
design/pcctc_pkg.sv
design/pcctc_front.sv
design/pcctc_queue.sv
design/pcctc_back.sv
design/point_cloud_crop_transform_colorize.sv
tb/testbench.sv
